// File: sv/msad_pkg.sv
// ----------------------------------------------------------------------------
// msad_pkg
// Shared widths, types and constants of the multiturn steering angle decoder.
// ----------------------------------------------------------------------------
package msad_pkg;

	localparam int unsigned MvW     = 13;
	localparam int unsigned GainW   = 16;
	localparam int unsigned OffW    = 15;
	localparam int unsigned AngleW  = 16;
	localparam int unsigned BaseW   = 14;
	localparam int unsigned ProdW   = MvW + GainW;
	localparam int unsigned TermW   = 14;
	localparam int unsigned SumW    = 16;
	localparam int unsigned SatW    = 15;
	localparam int unsigned ZoneW   = 4;
	localparam int unsigned NumZoneLevels = 8;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 16;

	localparam logic [ProdW:0] RoundHalf = (ProdW+1)'(32768);
	localparam logic signed [SumW-1:0] AngleLimit = SumW'(9000);

	typedef logic [MvW-1:0] mv_t;
	typedef logic [MvW-1:0] zone_levels_t [NumZoneLevels];

	localparam zone_levels_t ZoneLevel = '{
		MvW'(700), MvW'(1100), MvW'(1622), MvW'(2040),
		MvW'(2420), MvW'(2935), MvW'(3450), MvW'(4000)
	};

	typedef enum logic [CfgIdxW-1:0] {
		REG_P2_HALF   = 3'd0,
		REG_P1_HIGH   = 3'd1,
		REG_P1_LOW    = 3'd2,
		REG_GAIN      = 3'd3,
		REG_OFFSET    = 3'd4
	} cfg_reg_t;

	localparam mv_t                     RstP2Half = MvW'(2480);
	localparam mv_t                     RstP1High = MvW'(2360);
	localparam mv_t                     RstP1Low  = MvW'(2380);
	localparam logic [GainW-1:0]        RstGain   = GainW'(23783);
	localparam logic signed [OffW-1:0]  RstOffset = OffW'(1040);

	typedef struct packed {
		mv_t                     p2_half;
		mv_t                     p1_high;
		mv_t                     p1_low;
		logic [GainW-1:0]        gain;
		logic signed [OffW-1:0]  offset;
	} msad_cfg_t;

	// zone base, sign of the gain term and magnitude of its multiplicand
	typedef struct packed {
		logic signed [BaseW-1:0] base;
		logic                    neg;
		mv_t                     mag;
	} msad_term_t;

endpackage

// File: sv/msad_meas_if.sv
// ----------------------------------------------------------------------------
// msad_meas_if
// Sample channel: three track voltages per transaction.
// ----------------------------------------------------------------------------
interface msad_meas_if import msad_pkg::*; ();
	logic valid;
	logic ready;
	mv_t  p1_mv;
	mv_t  p2_mv;
	mv_t  p3_mv;

	modport source (output valid, p1_mv, p2_mv, p3_mv, input ready);
	modport sink (input valid, p1_mv, p2_mv, p3_mv, output ready);
endinterface

// File: sv/msad_angle_if.sv
// ----------------------------------------------------------------------------
// msad_angle_if
// Result channel: one steering angle per transaction.
// ----------------------------------------------------------------------------
interface msad_angle_if import msad_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [AngleW-1:0] angle_tenths;

	modport source (output valid, angle_tenths, input ready);
	modport sink (input valid, angle_tenths, output ready);
endinterface

// File: sv/msad_cfg_if.sv
// ----------------------------------------------------------------------------
// msad_cfg_if
// Register write channel: index and data per transaction.
// ----------------------------------------------------------------------------
interface msad_cfg_if import msad_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [CfgDatW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/msad_zone_decode.sv
// ----------------------------------------------------------------------------
// msad_zone_decode
// Picks the 180-degree zone from P3 and the direction from P1 and P2, and
// gives the zone base, term sign and multiplicand magnitude.
// ----------------------------------------------------------------------------
module msad_zone_decode import msad_pkg::*; (
	input  mv_t        p1_mv,
	input  mv_t        p2_mv,
	input  mv_t        p3_mv,
	input  msad_cfg_t  cfg,
	output msad_term_t term
);

	logic [ZoneW-1:0]   zone;
	logic signed [MvW:0] d_half;
	mv_t                 mag_half;
	logic                half_neg;
	logic                lt_low, gt_low, gt_high, p2_lt;
	logic                use_half, sub;
	logic signed [BaseW-1:0] base;

	always_comb begin
		zone = '0;
		for (int i = 0; i < NumZoneLevels; i++) begin
			zone = zone + ZoneW'(p3_mv >= ZoneLevel[i]);
		end
	end

	assign d_half   = $signed({1'b0, p2_mv}) - $signed({1'b0, cfg.p2_half});
	assign half_neg = d_half[MvW];
	assign mag_half = half_neg ? MvW'(-d_half) : d_half[MvW-1:0];

	assign lt_low  = p1_mv < cfg.p1_low;
	assign gt_low  = p1_mv > cfg.p1_low;
	assign gt_high = p1_mv > cfg.p1_high;
	assign p2_lt   = p2_mv < cfg.p2_half;

	always_comb begin
		use_half = 1'b0;
		sub      = 1'b0;
		base     = '0;
		unique case (zone)
			4'd0: begin
				if (lt_low && p2_lt) begin
					base = -BaseW'(7200); sub = 1'b1;
				end else if (gt_low) begin
					base = -BaseW'(7200);
				end else begin
					base = -BaseW'(8100); sub = 1'b1; use_half = 1'b1;
				end
			end
			4'd1: begin
				use_half = 1'b1;
				base = gt_high ? -BaseW'(6300) : -BaseW'(4500);
				sub  = !gt_high;
			end
			4'd2: begin
				base = -BaseW'(3600);
				sub  = lt_low;
			end
			4'd3: begin
				use_half = 1'b1;
				base = gt_high ? -BaseW'(2700) : -BaseW'(900);
				sub  = !gt_high;
			end
			4'd4: begin
				base = '0;
				sub  = lt_low;
			end
			4'd5: begin
				use_half = 1'b1;
				base = gt_high ? BaseW'(900) : BaseW'(2700);
				sub  = !gt_high;
			end
			4'd6: begin
				base = BaseW'(3600);
				sub  = lt_low;
			end
			4'd7: begin
				use_half = 1'b1;
				base = gt_high ? BaseW'(4500) : BaseW'(6300);
				sub  = !gt_high;
			end
			default: begin
				if (lt_low) begin
					base = BaseW'(7200); sub = 1'b1;
				end else if (gt_low && p2_lt) begin
					base = BaseW'(7200);
				end else begin
					base = BaseW'(8100); use_half = 1'b1;
				end
			end
		endcase
	end

	assign term.base = base;
	assign term.neg  = use_half ? (sub ^ half_neg) : sub;
	assign term.mag  = use_half ? mag_half : p2_mv;

endmodule

// File: sv/multiturn_steering_angle_decode_top.sv
// ----------------------------------------------------------------------------
// multiturn_steering_angle_decode_top
// Steering angle from three sensor track voltages, in tenths of a degree.
// ----------------------------------------------------------------------------
// One sample is taken every clock cycle unless held, and its angle is presented
// from the last of four register stages: zone decode, gain multiply, round and
// saturate, then offset and negation. The whole pipeline holds while an angle
// waits on the result channel. The user must write registers over the config
// channel between samples, when no transaction is in flight; this is not enforced.
module multiturn_steering_angle_decode_top import msad_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	msad_meas_if.sink    meas,
	msad_angle_if.source angle,
	msad_cfg_if.sink     cfg
);

	msad_cfg_t  cfg_q;
	msad_term_t term;
	logic       en;

	logic                    v_s1, v_s2, v_s3, v_s4;
	msad_term_t              term_s1;
	logic [ProdW-1:0]        prod_s2;
	logic                    neg_s2;
	logic signed [BaseW-1:0] base_s2;
	logic signed [SatW-1:0]  sat_s3;
	logic signed [AngleW-1:0] angle_s4;

	logic [ProdW:0]          rounded;
	logic [TermW-1:0]        gterm;
	logic signed [SumW-1:0]  sum;
	logic signed [SatW-1:0]  sat;
	logic signed [SumW-1:0]  with_off;

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p2_half <= RstP2Half;
			cfg_q.p1_high <= RstP1High;
			cfg_q.p1_low  <= RstP1Low;
			cfg_q.gain    <= RstGain;
			cfg_q.offset  <= RstOffset;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_P2_HALF: cfg_q.p2_half <= cfg.data[MvW-1:0];
				REG_P1_HIGH: cfg_q.p1_high <= cfg.data[MvW-1:0];
				REG_P1_LOW:  cfg_q.p1_low  <= cfg.data[MvW-1:0];
				REG_GAIN:    cfg_q.gain    <= cfg.data[GainW-1:0];
				REG_OFFSET:  cfg_q.offset  <= cfg.data[OffW-1:0];
				default: ;
			endcase
		end
	end

	msad_zone_decode u_zone (
		.p1_mv (meas.p1_mv),
		.p2_mv (meas.p2_mv),
		.p3_mv (meas.p3_mv),
		.cfg   (cfg_q),
		.term  (term)
	);

	assign en         = !v_s4 || angle.ready;
	assign meas.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= meas.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// round half away from zero on the magnitude
	assign rounded = {1'b0, prod_s2} + RoundHalf;
	assign gterm   = rounded[ProdW:GainW] & {TermW{1'b1}};
	assign sum     = neg_s2 ? SumW'(base_s2) - SumW'(gterm) : SumW'(base_s2) + SumW'(gterm);

	always_comb begin
		if (sum < -AngleLimit) begin
			sat = SatW'(-AngleLimit);
		end else if (sum > AngleLimit) begin
			sat = SatW'(AngleLimit);
		end else begin
			sat = sum[SatW-1:0];
		end
	end

	assign with_off = SumW'(sat_s3) + SumW'(cfg_q.offset);

	always_ff @(posedge clk) begin
		if (en) begin
			term_s1  <= term;
			prod_s2  <= ProdW'(term_s1.mag) * ProdW'(cfg_q.gain);
			neg_s2   <= term_s1.neg;
			base_s2  <= term_s1.base;
			sat_s3   <= sat;
			angle_s4 <= AngleW'(-with_off);
		end
	end

	assign angle.valid        = v_s4;
	assign angle.angle_tenths = angle_s4;

endmodule
